>>> src/xbpm_pkg.sv
// Shared types and constants for the XOR bit-pair mask finder.
// No dependencies; used by every module under src.
package xbpm_pkg;

	localparam int FIELD_BITS        = 30;
	localparam int COUNT_BITS        = 3;
	localparam int ADDR_WIDTH_DEF    = 30;
	localparam int MAX_MASKS_DEF     = 16;
	localparam int QUEUE_DEPTH       = 2;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 3'd7;
	localparam logic [COUNT_BITS-1:0] LIMIT_RESET = 3'd5;

	// One classified address on its way from the front to the back.
	typedef struct packed {
		logic [FIELD_BITS-1:0] address;
		logic                  is_first;
		logic                  last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> src/xor_bit_pair_mask_finder.sv
// XOR bit-pair mask finder top level: front end, item queue and back end; uses xbpm_pkg.
// Addresses: one beat per cycle while busy is low, each counted when the back end pops it.
// Last address: count pass over the NP = W*(W-1)/2 bit pairs (W = min(ADDR_WIDTH,30)), then
// an emit pass over the pairs; a result beat follows each survivor met, none can stall.
// A last address that arrives during a scan holds the queue; busy rises once two beats wait.
// Reset clears counters, reference and queue; outlier_limit returns to 5.
module xor_bit_pair_mask_finder #(
	parameter int ADDR_WIDTH = xbpm_pkg::ADDR_WIDTH_DEF,
	parameter int MAX_MASKS  = xbpm_pkg::MAX_MASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [29:0] address,
	input  logic        last,
	input  logic        outlier_limit_valid,
	output logic        outlier_limit_ready,
	input  logic [2:0]  outlier_limit,
	output logic        strobe,
	output logic [29:0] mask,
	output logic        valid_res,
	output logic        overflow,
	output logic        run_end
);
	import xbpm_pkg::*;

	logic [COUNT_BITS-1:0] limit_q;
	q_status_t             qs;
	item_t                 push_item;
	item_t                 pop_item;
	logic                  push;
	logic                  pop;

	assign outlier_limit_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (outlier_limit_valid && outlier_limit_ready) begin
			limit_q <= outlier_limit;
		end
	end

	xbpm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.address   (address),
		.last      (last),
		.qs        (qs),
		.push      (push),
		.push_item (push_item)
	);

	xbpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qs        (qs)
	);

	xbpm_back #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.MAX_MASKS  (MAX_MASKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit_q),
		.qs        (qs),
		.q_item    (pop_item),
		.pop       (pop),
		.strobe    (strobe),
		.mask      (mask),
		.valid_res (valid_res),
		.overflow  (overflow),
		.run_end   (run_end)
	);

	a_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !valid_res |-> run_end && !overflow && mask == '0)
		else $error("empty result is not a clean closing beat");

	a_two_bits: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && valid_res |-> $countones(mask) == 2)
		else $error("surviving mask does not hold exactly two bits");

	a_gap_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && run_end |=> !strobe)
		else $error("result beat right after the end of a run");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qs.empty)
		else $error("back end took an item from an empty queue");

endmodule

>>> src/xbpm_front.sv
// Front end: takes addresses on the start/busy handshake and tags the
// first address of each cluster. Depends on xbpm_pkg.
module xbpm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [29:0]       address,
	input  logic              last,
	input  xbpm_pkg::q_status_t qs,
	output logic              push,
	output xbpm_pkg::item_t   push_item
);
	import xbpm_pkg::*;

	logic has_ref_q;

	assign busy               = qs.full;
	assign push               = start && !qs.full;
	assign push_item.address  = address;
	assign push_item.is_first = !has_ref_q;
	assign push_item.last     = last;

	// a last beat closes the cluster, so the next beat starts a new one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_ref_q <= 1'b0;
		end else if (push) begin
			has_ref_q <= !last;
		end
	end

endmodule

>>> src/xbpm_queue.sv
// Short register queue between front and back end.
// Depends on xbpm_pkg for the item type and depth.
module xbpm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  xbpm_pkg::item_t     push_item,
	input  logic                pop,
	output xbpm_pkg::item_t     pop_item,
	output xbpm_pkg::q_status_t qs
);
	import xbpm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  count_q;

	assign qs.full  = (count_q == CW'(QUEUE_DEPTH));
	assign qs.empty = (count_q == '0);
	assign pop_item = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_q + PW'(1));
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_q + PW'(1));
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + CW'(1));
			end else if (pop && !push) begin
				count_q <= CW'(count_q - CW'(1));
			end
		end
	end

endmodule

>>> src/xbpm_back.sv
// Back end: per-pair mismatch counters, survivor capture on the last
// address, and the two-pass scan that emits masks. Depends on xbpm_pkg.
module xbpm_back #(
	parameter int ADDR_WIDTH = xbpm_pkg::ADDR_WIDTH_DEF,
	parameter int MAX_MASKS  = xbpm_pkg::MAX_MASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          limit,
	input  xbpm_pkg::q_status_t qs,
	input  xbpm_pkg::item_t     q_item,
	output logic                pop,
	output logic                strobe,
	output logic [29:0]         mask,
	output logic                valid_res,
	output logic                overflow,
	output logic                run_end
);
	import xbpm_pkg::*;

	localparam int W  = (ADDR_WIDTH < FIELD_BITS) ? ADDR_WIDTH : FIELD_BITS;
	localparam int NP = W * (W - 1) / 2;
	localparam int IW = $clog2(W);
	localparam int SW = $clog2(MAX_MASKS + 2);
	localparam int KW = $clog2(MAX_MASKS + 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_COUNT = 3'b010,
		S_EMIT  = 3'b100
	} scan_state_t;

	scan_state_t           state_q;
	logic [FIELD_BITS-1:0] ref_q;
	logic [FIELD_BITS-1:0] ref_eff;
	logic [FIELD_BITS-1:0] diff;
	logic [NP-1:0]         surv_now;
	logic [NP-1:0]         sv_q;
	logic [IW-1:0]         i_q;
	logic [IW-1:0]         j_q;
	logic [SW-1:0]         surv_q;
	logic [SW-1:0]         surv_nxt;
	logic [KW-1:0]         kept_q;
	logic [KW-1:0]         kept_inc;
	logic [KW-1:0]         total;
	logic                  last_pair;
	logic                  surv_inc;
	logic [FIELD_BITS-1:0] pair_mask;
	logic [NP-1:0]         sv_rot;

	// a last beat waits until the running scan has released the survivor vector
	assign pop     = !qs.empty && !(q_item.last && state_q != S_IDLE);
	assign ref_eff = q_item.is_first ? q_item.address : ref_q;
	assign diff    = q_item.address ^ ref_eff;

	for (genvar gi = 0; gi < W; gi++) begin : g_row
		for (genvar gj = gi + 1; gj < W; gj++) begin : g_col
			localparam int S = gi * (2 * W - gi - 1) / 2 + gj - gi - 1;
			logic [COUNT_BITS-1:0] cnt_q;
			logic [COUNT_BITS-1:0] cnt_nxt;

			assign cnt_nxt = ((diff[gi] ^ diff[gj]) && cnt_q != COUNT_MAX)
				? COUNT_BITS'(cnt_q + COUNT_BITS'(1)) : cnt_q;
			assign surv_now[S] = (cnt_nxt < limit);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					cnt_q <= '0;
				end else if (pop) begin
					cnt_q <= q_item.last ? '0 : cnt_nxt;
				end
			end
		end
	end

	always_comb begin
		last_pair = (i_q == IW'(W - 2)) && (j_q == IW'(W - 1));
		surv_inc  = sv_q[0] && (surv_q <= SW'(MAX_MASKS));
		surv_nxt  = SW'(surv_q + SW'(surv_inc));
		total     = (surv_q > SW'(MAX_MASKS)) ? KW'(MAX_MASKS) : KW'(surv_q);
		kept_inc  = KW'(kept_q + KW'(1));
		pair_mask = (FIELD_BITS'(1) << i_q) | (FIELD_BITS'(1) << j_q);
		sv_rot    = (sv_q >> 1) | (NP'(sv_q[0]) << (NP - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
		end else if (pop) begin
			if (q_item.last) begin
				ref_q <= '0;
			end else if (q_item.is_first) begin
				ref_q <= q_item.address;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			strobe  <= 1'b0;
			sv_q    <= '0;
			i_q     <= '0;
			j_q     <= IW'(1);
			surv_q  <= '0;
			kept_q  <= '0;
		end else begin
			strobe <= 1'b0;
			if (state_q != S_IDLE) begin
				// rotate the survivors and step to the next pair
				sv_q <= sv_rot;
				if (j_q == IW'(W - 1)) begin
					i_q <= IW'(i_q + IW'(1));
					j_q <= IW'(i_q + IW'(2));
				end else begin
					j_q <= IW'(j_q + IW'(1));
				end
			end
			case (state_q)
				S_IDLE: begin
					if (pop && q_item.last) begin
						sv_q    <= surv_now;
						i_q     <= '0;
						j_q     <= IW'(1);
						surv_q  <= '0;
						kept_q  <= '0;
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					surv_q <= surv_nxt;
					if (last_pair) begin
						i_q <= '0;
						j_q <= IW'(1);
						if (surv_nxt == '0) begin
							strobe  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (sv_q[0]) begin
						strobe <= 1'b1;
						kept_q <= kept_inc;
						if (kept_inc == total) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_COUNT: begin
				mask      <= '0;
				valid_res <= 1'b0;
				overflow  <= 1'b0;
				run_end   <= 1'b1;
			end
			S_EMIT: begin
				mask      <= pair_mask;
				valid_res <= 1'b1;
				overflow  <= (surv_q > SW'(MAX_MASKS));
				run_end   <= (kept_inc == total);
			end
			default: begin
				mask      <= mask;
				valid_res <= valid_res;
				overflow  <= overflow;
				run_end   <= run_end;
			end
		endcase
	end

endmodule
